[rtl/mufa_pkg.sv]
// mufa_pkg: constants, codes and the coordinate fold helper of the
// mirrored unit fold accumulator; used by mirrored_unit_fold_accumulator
package mufa_pkg;

  // accumulator geometry (ACC_DIM and MAX_IMAGE_DIM are powers of two)
  localparam int ACC_DIM       = 128;
  localparam int ACC_AW        = $clog2(ACC_DIM);
  localparam int ADDR_W        = 2 * ACC_AW;
  localparam int ACC_BITS      = 40;
  localparam int MAX_IMAGE_DIM = 4096;
  localparam int PIX_W         = $clog2(MAX_IMAGE_DIM);
  localparam int SAMPLE_W      = 16;

  // fixed point coordinate arithmetic
  localparam int Q_SHIFT  = 16;
  localparam int STEP_W   = 19;
  localparam int ORIGIN_W = 32;
  localparam int PROD_W   = STEP_W + PIX_W;
  // only the bits up to the fold period matter for the folded coordinate
  localparam int T_W      = Q_SHIFT + ACC_AW + 1;
  localparam logic [T_W-1:0] Q_HALF = T_W'(1) << (Q_SHIFT - 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ORIGIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 2'd2;

  localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(65536);
  localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = ORIGIN_W'(4194304);

  // commands
  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // saturation limits
  localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // floor(t / 2^Q) mod 2*ACC_DIM, then mirrored into 0 .. ACC_DIM-1
  function automatic logic [ACC_AW-1:0] fold_coord(input logic [T_W-1:0] t);
    logic [ACC_AW:0] m;
    m = t[T_W-1:Q_SHIFT];
    return m[ACC_AW] ? ~m[ACC_AW-1:0] : m[ACC_AW-1:0];
  endfunction

endpackage

[rtl/mirrored_unit_fold_accumulator.sv]
// mirrored_unit_fold_accumulator: folds signed pixel samples into a
// saturating accumulator store held in one synchronous memory
// depends on mufa_pkg
//
//  channel  direction  handshake              payload
//  pix      in         pix_valid / pix_ready  cmd, sample, pixel_col, pixel_row,
//                                             read_col, read_row
//  res      out        res_valid / res_ready  acc_value
//  cfg      in         cfg_we (no wait)       cfg_index, cfg_data
//
// one transaction a cycle while the pipeline does not hold; a read result is offered
// once it has passed the stages (products registered, then address and memory read, then
// modify, write back and output register load on one edge)
// a read-modify-write loop on the memory, closed by a forwarding register that covers
// the write landing on the same edge as the next read
// after reset a clearing pass writes zero to all 16384 entries, one a cycle;
// pix_ready stays low until the pass ends
// the whole pipeline holds only while a read result waits in the output
// register and a further read reaches write back

module mirrored_unit_fold_accumulator (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_we,
  input  logic [mufa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mufa_pkg::CFG_DATA_W-1:0]        cfg_data,
  // pixel / command channel
  input  logic                                   pix_valid,
  output logic                                   pix_ready,
  input  logic                                   cmd,
  input  logic signed [mufa_pkg::SAMPLE_W-1:0]   sample,
  input  logic [mufa_pkg::PIX_W-1:0]             pixel_col,
  input  logic [mufa_pkg::PIX_W-1:0]             pixel_row,
  input  logic [mufa_pkg::ACC_AW-1:0]            read_col,
  input  logic [mufa_pkg::ACC_AW-1:0]            read_row,
  // result channel
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic signed [mufa_pkg::ACC_BITS-1:0]   acc_value
);

  // configuration registers
  logic [mufa_pkg::STEP_W-1:0]   step_size;
  logic [mufa_pkg::ORIGIN_W-1:0] origin_x;
  logic [mufa_pkg::ORIGIN_W-1:0] origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= mufa_pkg::STEP_RESET;
      origin_x  <= mufa_pkg::ORIGIN_RESET;
      origin_y  <= mufa_pkg::ORIGIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mufa_pkg::CFG_STEP_SIZE: step_size <= cfg_data[mufa_pkg::STEP_W-1:0];
        mufa_pkg::CFG_ORIGIN_X:  origin_x  <= cfg_data;
        mufa_pkg::CFG_ORIGIN_Y:  origin_y  <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // clearing pass after reset
  logic                        clr_busy;
  logic [mufa_pkg::ADDR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (&clr_cnt) clr_busy <= 1'b0;
    end
  end

  // pipeline control
  logic valid_a, valid_b;
  logic cmd_b;
  logic adv;        // whole pipeline moves on this edge
  logic pix_accept;

  // hold only when a read must load the output register and it is still full
  assign adv        = !(valid_b && (cmd_b == mufa_pkg::CMD_READ) && res_valid && !res_ready);
  assign pix_ready  = !clr_busy && (adv || !valid_a);
  assign pix_accept = pix_valid && pix_ready;

  // stage a: transaction captured, coordinate products registered
  logic                                 cmd_a;
  logic signed [mufa_pkg::SAMPLE_W-1:0] sample_a;
  logic [mufa_pkg::T_W-1:0]             prod_x_a, prod_y_a;
  logic [mufa_pkg::ACC_AW-1:0]          rcol_a, rrow_a;
  logic [mufa_pkg::PROD_W-1:0]          prod_x, prod_y;

  assign prod_x = mufa_pkg::PROD_W'(step_size) * mufa_pkg::PROD_W'(pixel_col);
  assign prod_y = mufa_pkg::PROD_W'(step_size) * mufa_pkg::PROD_W'(pixel_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (adv) begin
      valid_a <= pix_accept;
    end else begin
      valid_a <= valid_a || pix_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      cmd_a    <= cmd;
      sample_a <= sample;
      prod_x_a <= prod_x[mufa_pkg::T_W-1:0];
      prod_y_a <= prod_y[mufa_pkg::T_W-1:0];
      rcol_a   <= read_col;
      rrow_a   <= read_row;
    end
  end

  // entry address: origin + step*index + half, folded and mirrored per axis; reads take read_row/read_col
  logic [mufa_pkg::T_W-1:0]    t_x, t_y;
  logic [mufa_pkg::ACC_AW-1:0] cx, cy;
  logic [mufa_pkg::ADDR_W-1:0] raddr_a;

  assign t_x = origin_x[mufa_pkg::T_W-1:0] + prod_x_a + mufa_pkg::Q_HALF;
  assign t_y = origin_y[mufa_pkg::T_W-1:0] + prod_y_a + mufa_pkg::Q_HALF;
  assign cx  = mufa_pkg::fold_coord(t_x);
  assign cy  = mufa_pkg::fold_coord(t_y);

  always_comb begin
    case (cmd_a)
      mufa_pkg::CMD_READ: raddr_a = {rrow_a, rcol_a};
      default:            raddr_a = {cy, cx};
    endcase
  end

  // stage b: memory read issued on entry, modify and write back here
  logic signed [mufa_pkg::SAMPLE_W-1:0] sample_b;
  logic [mufa_pkg::ADDR_W-1:0]          addr_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (adv) begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_b    <= cmd_a;
      sample_b <= sample_a;
      addr_b   <= raddr_a;
    end
  end

  // accumulator store
  logic [mufa_pkg::ACC_BITS-1:0] fold_mem [mufa_pkg::ACC_DIM*mufa_pkg::ACC_DIM];
  logic [mufa_pkg::ACC_BITS-1:0] rd_data;
  logic                          mem_we;
  logic [mufa_pkg::ADDR_W-1:0]   mem_waddr;
  logic [mufa_pkg::ACC_BITS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) fold_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (adv) rd_data <= fold_mem[raddr_a];
  end

  // forwarding: the write on the edge of stage b's read is missing from rd_data
  logic                          fw_valid;
  logic [mufa_pkg::ADDR_W-1:0]   fw_addr;
  logic [mufa_pkg::ACC_BITS-1:0] fw_data;
  logic [mufa_pkg::ACC_BITS-1:0] cur;
  logic [mufa_pkg::ACC_BITS:0]   sum;
  logic [mufa_pkg::ACC_BITS-1:0] sat;
  logic [mufa_pkg::ACC_BITS-1:0] new_val;
  logic                          wb_we;

  assign cur = (fw_valid && (fw_addr == addr_b)) ? fw_data : rd_data;

  // one extra bit catches overflow; the two top bits differ on overflow
  assign sum = {cur[mufa_pkg::ACC_BITS-1], cur}
             + {{(mufa_pkg::ACC_BITS+1-mufa_pkg::SAMPLE_W){sample_b[mufa_pkg::SAMPLE_W-1]}},
                sample_b};

  always_comb begin
    case (sum[mufa_pkg::ACC_BITS:mufa_pkg::ACC_BITS-1])
      2'b01:   sat = mufa_pkg::ACC_MAX;
      2'b10:   sat = mufa_pkg::ACC_MIN;
      default: sat = sum[mufa_pkg::ACC_BITS-1:0];
    endcase
  end

  // a read hands out the entry and clears it
  assign new_val = (cmd_b == mufa_pkg::CMD_READ) ? '0 : sat;
  assign wb_we   = valid_b && adv;

  always_comb begin
    if (clr_busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = wb_we;
      mem_waddr = addr_b;
      mem_wdata = new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (adv) begin
      fw_valid <= wb_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_addr <= addr_b;
      fw_data <= new_val;
    end
  end

  // output register
  logic load_res;
  assign load_res = wb_we && (cmd_b == mufa_pkg::CMD_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) acc_value <= cur;
  end

  // checks
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (!pix_ready && !valid_a && !valid_b && !fw_valid))
    else $error("pipeline active during clearing pass");

  a_read_delivers: assert property (@(posedge clk) disable iff (rst)
    load_res |=> res_valid)
    else $error("read transaction left no result");

  a_hold_stage_b: assert property (@(posedge clk) disable iff (rst)
    (valid_b && !adv) |=> (valid_b && $stable(addr_b) && $stable(rd_data)))
    else $error("stage b changed while held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !load_res)
    else $error("result register overwritten before transfer");

endmodule

[tb/tb_mirrored_unit_fold_accumulator.sv]
// self-checking testbench of mirrored_unit_fold_accumulator: directed and random pixel traffic,
// predicted sums checked against every read result; depends on mufa_pkg and the block itself
module tb_mirrored_unit_fold_accumulator;
  import mufa_pkg::*;

  localparam int CLK_PERIOD = 8;
  // slack after the last owed result, so trailing accumulates retire
  localparam int DRAIN_CYCLES = 8;
  // hold-off of the result side while pixels keep coming
  localparam int HOLD_CYCLES = 300;
  // covers the clearing pass after reset and the slowest legal run many times over
  localparam int LIMIT_CYCLES = 400000;
  localparam int IDLE_PCT = 37;
  localparam int RECENT_DEPTH = 16;
  // index that selects no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint HALF_UNIT = longint'(1) << (Q_SHIFT - 1);
  localparam longint SUM_MAX = (longint'(1) <<< (ACC_BITS - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  // shadow of the fold store, the registers and the sums that reads still owe us
  class fold_tracker;
    longint sums[ACC_DIM*ACC_DIM];
    logic [STEP_W-1:0] step;
    logic signed [ORIGIN_W-1:0] org_x;
    logic signed [ORIGIN_W-1:0] org_y;
    logic signed [ACC_BITS-1:0] owed_sums[$];
    int faults;

    function new();
      foreach (sums[i]) sums[i] = 0;
      step = STEP_RESET;
      org_x = ORIGIN_RESET;
      org_y = ORIGIN_RESET;
      faults = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_STEP_SIZE: step = data[STEP_W-1:0];
        CFG_ORIGIN_X:  org_x = data;
        CFG_ORIGIN_Y:  org_y = data;
        default: ;
      endcase
    endfunction

    // origin + step * index, rounded half up; bits above the fold period fall away,
    // which is floor modulo for negative values too
    function int unsigned axis(logic signed [ORIGIN_W-1:0] origin, logic [PIX_W-1:0] index);
      longint t;
      int unsigned m;
      t = longint'(origin) + longint'(step) * longint'(index) + HALF_UNIT;
      m = t[Q_SHIFT + ACC_AW -: ACC_AW + 1];
      return (m >= ACC_DIM) ? (2 * ACC_DIM - 1 - m) : m;
    endfunction

    function int unsigned entry_of(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      return axis(org_y, row) * ACC_DIM + axis(org_x, col);
    endfunction

    // note one accepted transaction
    function void absorb(logic c, logic signed [SAMPLE_W-1:0] s, logic [PIX_W-1:0] pc,
                         logic [PIX_W-1:0] pr, logic [ACC_AW-1:0] rc, logic [ACC_AW-1:0] rr);
      int unsigned e;
      longint v;
      if (c == CMD_ACC) begin
        e = entry_of(pc, pr);
        v = sums[e] + longint'(s);
        if (v > SUM_MAX) v = SUM_MAX;
        if (v < SUM_MIN) v = SUM_MIN;
        sums[e] = v;
      end else begin
        e = rr * ACC_DIM + rc;
        owed_sums.insert(owed_sums.size(), ACC_BITS'(sums[e]));
        sums[e] = 0;
      end
    endfunction

    function void compare(logic signed [ACC_BITS-1:0] got);
      logic signed [ACC_BITS-1:0] want;
      if (owed_sums.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result: acc_value %0d", got);
        return;
      end
      want = owed_sums.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= 10) $display("acc_value mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int owed();
      return owed_sums.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic pix_valid;
  logic pix_ready;
  logic cmd;
  logic signed [SAMPLE_W-1:0] sample;
  logic [PIX_W-1:0] pixel_col;
  logic [PIX_W-1:0] pixel_row;
  logic [ACC_AW-1:0] read_col;
  logic [ACC_AW-1:0] read_row;
  logic res_valid;
  logic res_ready;
  logic signed [ACC_BITS-1:0] acc_value;

  fold_tracker tracker;
  // store entries hit lately, so reads mostly find something non-zero
  int unsigned recent_entries[$];
  bit tx_idle;
  bit rx_steady;
  bit hold_req;

  mirrored_unit_fold_accumulator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .cmd       (cmd),
    .sample    (sample),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .read_col  (read_col),
    .read_row  (read_row),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .acc_value (acc_value)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // safety net: ends a hung run
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random back-pressure, steady stretches, and one long hold-off
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_steady) begin
        res_ready = 1'b1;
      end else begin
        res_ready = ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // every result transaction is checked against the oldest owed sum
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) tracker.compare(acc_value);
  end

  // register write, only ever issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    tracker.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // offer one pixel transaction and hold it until the block takes it
  task automatic offer(input logic c, input logic signed [SAMPLE_W-1:0] s,
                       input logic [PIX_W-1:0] pc, input logic [PIX_W-1:0] pr,
                       input logic [ACC_AW-1:0] rc, input logic [ACC_AW-1:0] rr);
    @(negedge clk);
    while (tx_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_valid = 1'b0;
      @(negedge clk);
    end
    cmd = c;
    sample = s;
    pixel_col = pc;
    pixel_row = pr;
    read_col = rc;
    read_row = rr;
    pix_valid = 1'b1;
    do @(posedge clk); while (!pix_ready);
    if (c == CMD_ACC) begin
      recent_entries.insert(recent_entries.size(), tracker.entry_of(pc, pr));
      if (recent_entries.size() > RECENT_DEPTH) void'(recent_entries.pop_front());
    end
    tracker.absorb(c, s, pc, pr, rc, rr);
  endtask

  // read the entry that a given pixel lands on under the current registers
  task automatic read_pixel_entry(input logic [PIX_W-1:0] pc, input logic [PIX_W-1:0] pr);
    int unsigned e;
    e = tracker.entry_of(pc, pr);
    offer(CMD_READ, SAMPLE_W'($urandom), pc, pr, ACC_AW'(e % ACC_DIM), ACC_AW'(e / ACC_DIM));
  endtask

  // drop valid, let all owed results arrive, then let trailing accumulates retire
  task automatic settle();
    @(negedge clk);
    pix_valid = 1'b0;
    while (tracker.owed() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_item(input int read_pct);
    logic c;
    logic signed [SAMPLE_W-1:0] s;
    logic [PIX_W-1:0] pc;
    logic [PIX_W-1:0] pr;
    logic [ACC_AW-1:0] rc;
    logic [ACC_AW-1:0] rr;
    int unsigned e;
    int pick;
    c = ($urandom_range(0, 99) < read_pct) ? CMD_READ : CMD_ACC;
    s = SAMPLE_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) s = 16'sh7FFF;
    else if (pick == 1) s = 16'sh8000;
    pc = PIX_W'($urandom);
    pr = PIX_W'($urandom);
    // a quarter of the pixels near the image corner, where coordinates cluster
    if ($urandom_range(0, 3) == 0) begin
      pc = PIX_W'($urandom_range(0, 40));
      pr = PIX_W'($urandom_range(0, 40));
    end
    rc = ACC_AW'($urandom);
    rr = ACC_AW'($urandom);
    if (c == CMD_READ && recent_entries.size() > 0 && $urandom_range(0, 99) < 70) begin
      e = recent_entries[$urandom_range(0, recent_entries.size() - 1)];
      rc = ACC_AW'(e % ACC_DIM);
      rr = ACC_AW'(e / ACC_DIM);
    end
    offer(c, s, pc, pr, rc, rr);
  endtask

  // one register setting followed by a burst of random transactions
  task automatic run_phase(input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] ox,
                           input logic [CFG_DATA_W-1:0] oy, input int n, input int read_pct,
                           input bit quiet, input bit squeeze);
    settle();
    write_reg(CFG_STEP_SIZE, step);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    tx_idle = !quiet;
    rx_steady = quiet;
    // result side stalls while reads pile up behind it
    if (squeeze) hold_req = 1'b1;
    repeat (n) random_item(read_pct);
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_STEP_SIZE;
    cfg_data = '0;
    pix_valid = 1'b0;
    cmd = CMD_ACC;
    sample = '0;
    pixel_col = '0;
    pixel_row = '0;
    read_col = '0;
    read_row = '0;
    tx_idle = 1'b1;
    rx_steady = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // registers at reset values: extremes of sample and pixel index, mirror edge
    offer(CMD_ACC, 16'sh7FFF, 12'h000, 12'h000, 7'h00, 7'h00);
    offer(CMD_ACC, 16'sh7FFF, 12'h000, 12'h000, 7'h00, 7'h00);
    offer(CMD_ACC, 16'sh8000, 12'hFFF, 12'hFFF, 7'h7F, 7'h7F);
    offer(CMD_ACC, -16'sd1, 12'd63, 12'd64, 7'h00, 7'h00);
    offer(CMD_ACC, 16'sd1, 12'd64, 12'd63, 7'h00, 7'h00);
    offer(CMD_ACC, 16'sh5555, 12'hAAA, 12'h555, 7'h2A, 7'h55);
    read_pixel_entry(12'h000, 12'h000);
    // second read of the same entry sees it cleared
    read_pixel_entry(12'h000, 12'h000);
    read_pixel_entry(12'hFFF, 12'hFFF);
    read_pixel_entry(12'd63, 12'd64);
    read_pixel_entry(12'hAAA, 12'h555);
    // entries never accumulated into read back as zero
    offer(CMD_READ, 16'sd0, 12'h000, 12'h000, 7'h00, 7'h7F);
    offer(CMD_READ, 16'sh7FFF, 12'hFFF, 12'hFFF, 7'h55, 7'h2A);

    // exactly halfway origin rounds up, negative origin folds and mirrors
    settle();
    write_reg(CFG_ORIGIN_X, 32'h0000_8000);
    write_reg(CFG_ORIGIN_Y, 32'hFFFA_8000);
    offer(CMD_ACC, 16'sd100, 12'h000, 12'h000, 7'h00, 7'h00);
    read_pixel_entry(12'h000, 12'h000);

    // zero step via upper data bits being dropped, just-below-half origin, spare index
    settle();
    write_reg(CFG_STEP_SIZE, 32'hFFF8_0000);
    write_reg(CFG_ORIGIN_X, 32'h0000_7FFF);
    write_reg(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    tx_idle = 1'b0;
    rx_steady = 1'b1;
    // back-to-back hits on one entry exercise the forwarding path
    offer(CMD_ACC, SAMPLE_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 7'h00, 7'h00);
    offer(CMD_ACC, SAMPLE_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 7'h00, 7'h00);
    offer(CMD_ACC, SAMPLE_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 7'h00, 7'h00);
    read_pixel_entry(PIX_W'($urandom), PIX_W'($urandom));
    offer(CMD_ACC, 16'sh7FFF, PIX_W'($urandom), PIX_W'($urandom), 7'h00, 7'h00);
    read_pixel_entry(PIX_W'($urandom), PIX_W'($urandom));

    // random phases over several register settings, extremes among them
    run_phase(32'd65536, $urandom, $urandom, 100, 40, 1'b0, 1'b0);
    run_phase(32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 80, 40, 1'b0, 1'b0);
    run_phase(32'd524287, 32'h7FFF_FFFF, 32'h8000_0000, 80, 40, 1'b0, 1'b0);
    run_phase(32'd0, $urandom, $urandom, 60, 40, 1'b1, 1'b0);
    run_phase(32'd16384, $urandom, $urandom, 100, 70, 1'b0, 1'b1);
    run_phase($urandom_range(1, 524287), $urandom, $urandom, 120, 40, 1'b0, 1'b0);
    run_phase(32'd131072, $urandom, $urandom, 100, 40, 1'b1, 1'b0);
    run_phase($urandom_range(1, 524287), $urandom, $urandom, 60, 40, 1'b0, 1'b0);

    settle();
    if (tracker.owed() != 0) tracker.faults++;
    if (tracker.faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
